FILE: hdl/bast_pkg.sv
// Shared constants, types and helpers for the block average / deviation core.
// Used by every module under hdl; depends on nothing else.
package bast_pkg;

    localparam int AVG_MAX   = 1024;
    localparam int CHANNELS  = 4;
    localparam int SMP_W     = 32;
    localparam int CNT_W     = 11;
    localparam int IDX_W     = $clog2(AVG_MAX);
    localparam int LANE_W    = 2;
    localparam int ADDR_W    = IDX_W + LANE_W;
    localparam int SUM_W     = SMP_W + IDX_W;
    localparam int SQ_W      = 2 * SMP_W + 1;
    localparam int ACC_W     = SQ_W + IDX_W;
    localparam int DIV_W     = ACC_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int ROOT_W    = SMP_W;
    localparam int RAD_W     = 2 * ROOT_W;

    localparam logic [3:0] ALL_LANES = 4'h0F;

    // Configuration register indexes.
    localparam logic REG_CHANNEL_ENABLE = 1'b0;
    localparam logic REG_AVERAGE_COUNT  = 1'b1;

    typedef logic signed [SMP_W-1:0] sample_t;

    // Clamp a 33-bit signed difference to the signed 32-bit range.
    function automatic sample_t sat32(input logic signed [SMP_W:0] v);
        sample_t r;
        if (v[SMP_W] != v[SMP_W-1]) begin
            r = v[SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/block_average_stddev_with_tare_core.sv
// Top level of the block average / standard deviation core with tare offsets.
// Depends on bast_pkg, bast_divider and bast_isqrt.
//
// Usage: the s_ channel takes one word of four 32-bit length samples
// (s_tdata) with a zero request flag (s_tuser). The m_ channel gives one word
// per enabled lane, lanes ascending, m_tlast on the last one of an input word.
// Registers are written on the cfg_ channel (index 0 channel_enable, index 1
// average_count) by the user only while the core is idle; the core does not
// enforce this. cfg_ready is high out of reset. Pass-through (count 0 or 1):
// the lanes are visited in turn, an enabled one waiting on a busy output
// register; a lane's result is registered and appears in the cycle after it is visited.
// Averaging: each word writes its lanes into the sample memory (one write
// port, one lane per cycle). The word that completes a block then costs, per
// enabled lane, two read passes over the lane's N stored samples (one memory
// read per cycle), a serial divide for the mean, another for the variance,
// and a square root. The core takes a new word only when it is idle.
// Reset clears tare offsets, the block index and the zeroing mode and sets
// the registers to channel_enable 0xF, average_count 10; no memory clearing.
// A stalled receiver holds the output register and the core waits on it.
module block_average_stddev_with_tare_core (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: length_a[31:0], length_b[63:32], length_c[95:64], length_d[127:96]
    input  logic [127:0] s_tdata,
    // s_tuser: zero_request[0]
    input  logic         s_tuser,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m_tdata: position[31:0], deviation[63:32]
    output logic [63:0]  m_tdata,
    // m_tuser: channel[1:0], averaged[2]
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_addr,
    input  logic [10:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PASS, ST_STORE, ST_LANE, ST_SUM, ST_DIVM,
        ST_SQ, ST_DIVV, ST_SQRT, ST_RES
    } state_t;

    state_t                                  state_reg;
    logic [3:0]                              en_reg;
    logic [bast_pkg::CNT_W-1:0]              count_reg;
    bast_pkg::sample_t                       tare_reg [bast_pkg::CHANNELS];
    bast_pkg::sample_t                       smp_reg [bast_pkg::CHANNELS];
    logic [bast_pkg::CNT_W-1:0]              sample_index_reg;
    logic [bast_pkg::CNT_W-1:0]              store_idx_reg;
    logic                                    zeroing_reg;
    logic [bast_pkg::LANE_W-1:0]             lane_reg;
    logic [bast_pkg::CNT_W-1:0]              n_reg;
    logic [bast_pkg::CNT_W-1:0]              cnt_reg;
    logic                                    rd_pend_reg;
    logic signed [bast_pkg::SUM_W-1:0]       sum_reg;
    bast_pkg::sample_t                       mean_reg;
    bast_pkg::sample_t                       pos_reg;
    logic [bast_pkg::SMP_W:0]                absd_reg;
    logic                                    absd_vld_reg;
    logic [bast_pkg::SQ_W-1:0]               sq_reg;
    logic                                    sq_vld_reg;
    logic [bast_pkg::ACC_W-1:0]              acc_reg;
    logic [bast_pkg::ROOT_W-1:0]             dev_reg;
    logic                                    div_start_reg;
    logic [bast_pkg::DIV_W-1:0]              div_dividend_reg;
    logic [bast_pkg::CNT_W-1:0]              div_divisor_reg;
    logic                                    sqrt_start_reg;
    logic [bast_pkg::RAD_W-1:0]              rad_reg;
    logic [63:0]                             out_data_reg;
    logic [2:0]                              out_user_reg;
    logic                                    out_last_reg;
    logic                                    out_valid_reg;

    // Sample memory, one row of AVG_MAX words per lane.
    logic [bast_pkg::SMP_W-1:0]  mem [bast_pkg::AVG_MAX * bast_pkg::CHANNELS];
    logic [bast_pkg::SMP_W-1:0]  mem_q;
    logic                        mem_we;
    logic [bast_pkg::ADDR_W-1:0] mem_waddr;
    logic                        mem_re;
    logic [bast_pkg::ADDR_W-1:0] mem_raddr;

    logic                                div_done;
    logic                                div_busy;
    logic [bast_pkg::DIV_W-1:0]          div_q;
    logic                                sqrt_done;
    logic [bast_pkg::ROOT_W-1:0]         sqrt_root;

    logic [bast_pkg::CNT_W-1:0]          n_eff;
    logic                                in_accept;
    logic                                out_free;
    logic                                out_load;
    logic                                lane_en;
    logic                                lane_last;
    logic                                scan_busy;
    bast_pkg::sample_t                   pass_pos;
    logic [bast_pkg::CNT_W-1:0]          base_idx;
    logic [bast_pkg::CNT_W-1:0]          idx_next;
    logic signed [bast_pkg::SMP_W:0]     diff;
    bast_pkg::sample_t                   mean_new;
    logic                                var_sat;

    // Effective block length, saturated at the memory depth.
    assign n_eff = (count_reg > bast_pkg::CNT_W'(bast_pkg::AVG_MAX))
                   ? bast_pkg::CNT_W'(bast_pkg::AVG_MAX) : count_reg;

    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = aresetn;
    assign out_free  = !out_valid_reg || m_tready;
    assign lane_en   = en_reg[lane_reg];
    assign lane_last = (en_reg >> lane_reg) == 4'b0001;
    assign scan_busy = (cnt_reg < n_reg);
    assign pass_pos  = bast_pkg::sat32({smp_reg[lane_reg][31], smp_reg[lane_reg]}
                                       - {tare_reg[lane_reg][31], tare_reg[lane_reg]});
    assign base_idx  = s_tuser ? '0 : sample_index_reg;
    assign idx_next  = store_idx_reg + 1'b1;
    assign diff      = {mem_q[31], mem_q} - {mean_reg[31], mean_reg};
    assign mean_new  = sum_reg[bast_pkg::SUM_W-1] ? -div_q[bast_pkg::SMP_W-1:0]
                                                  : div_q[bast_pkg::SMP_W-1:0];
    assign var_sat   = div_q[bast_pkg::DIV_W-1:bast_pkg::RAD_W] != '0
                       || acc_reg[bast_pkg::ACC_W-1:bast_pkg::RAD_W] >= n_reg - 1'b1;
    assign out_load  = out_free && lane_en
                       && ((state_reg == ST_PASS) || (state_reg == ST_RES && !zeroing_reg));

    // Memory access: writes only while storing, reads only in the two scan
    // passes, so the same entry is never written and read at once.
    assign mem_we    = (state_reg == ST_STORE) && lane_en;
    assign mem_waddr = {lane_reg, store_idx_reg[bast_pkg::IDX_W-1:0]};
    assign mem_re    = ((state_reg == ST_SUM) || (state_reg == ST_SQ)) && scan_busy;
    assign mem_raddr = {lane_reg, cnt_reg[bast_pkg::IDX_W-1:0]};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= smp_reg[lane_reg];
        end
        if (mem_re) begin
            mem_q <= mem[mem_raddr];
        end
    end

    bast_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_dividend_reg),
        .divisor  (div_divisor_reg),
        .done     (div_done),
        .busy     (div_busy),
        .quotient (div_q)
    );

    bast_isqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start_reg),
        .radicand (rad_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg    <= bast_pkg::ALL_LANES;
            count_reg <= bast_pkg::CNT_W'(10);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                bast_pkg::REG_CHANNEL_ENABLE: en_reg <= cfg_data[3:0] & bast_pkg::ALL_LANES;
                bast_pkg::REG_AVERAGE_COUNT:  count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            sample_index_reg <= '0;
            zeroing_reg      <= 1'b0;
            lane_reg         <= '0;
            cnt_reg          <= '0;
            rd_pend_reg      <= 1'b0;
            absd_vld_reg     <= 1'b0;
            sq_vld_reg       <= 1'b0;
            div_start_reg    <= 1'b0;
            sqrt_start_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < bast_pkg::CHANNELS; i++) begin
                tare_reg[i] <= '0;
            end
        end else begin
            // Start pulses for the divider and the square root.
            div_start_reg  <= ((state_reg == ST_SUM) && !scan_busy && !rd_pend_reg)
                              || ((state_reg == ST_SQ) && !scan_busy && !rd_pend_reg
                                  && !absd_vld_reg && !sq_vld_reg);
            sqrt_start_reg <= (state_reg == ST_DIVV) && div_done;
            rd_pend_reg    <= mem_re;

            // Result word register.
            if (out_load) begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= lane_last;
                if (state_reg == ST_PASS) begin
                    out_data_reg <= {32'd0, pass_pos};
                    out_user_reg <= {1'b0, lane_reg};
                end else begin
                    out_data_reg <= {dev_reg, pos_reg};
                    out_user_reg <= {1'b1, lane_reg};
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        for (int i = 0; i < bast_pkg::CHANNELS; i++) begin
                            smp_reg[i] <= s_tdata[i*bast_pkg::SMP_W +: bast_pkg::SMP_W];
                            if (s_tuser) begin
                                tare_reg[i] <= '0;
                            end
                        end
                        lane_reg <= '0;
                        n_reg    <= n_eff;
                        if (n_eff <= bast_pkg::CNT_W'(1)) begin
                            if (!s_tuser) begin
                                state_reg <= ST_PASS;
                            end
                        end else begin
                            if (s_tuser) begin
                                zeroing_reg <= 1'b1;
                            end
                            store_idx_reg <= (base_idx >= n_eff) ? '0 : base_idx;
                            state_reg     <= ST_STORE;
                        end
                    end
                end

                ST_PASS: begin
                    if (!lane_en || out_free) begin
                        lane_reg <= lane_reg + 1'b1;
                        if (lane_reg == bast_pkg::LANE_W'(bast_pkg::CHANNELS - 1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_STORE: begin
                    lane_reg <= lane_reg + 1'b1;
                    if (lane_reg == bast_pkg::LANE_W'(bast_pkg::CHANNELS - 1)) begin
                        sample_index_reg <= idx_next;
                        state_reg        <= (idx_next == n_reg) ? ST_LANE : ST_IDLE;
                    end
                end

                ST_LANE: begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                    if (lane_en) begin
                        state_reg <= ST_SUM;
                    end else if (lane_reg == bast_pkg::LANE_W'(bast_pkg::CHANNELS - 1)) begin
                        zeroing_reg      <= 1'b0;
                        sample_index_reg <= '0;
                        state_reg        <= ST_IDLE;
                    end else begin
                        lane_reg <= lane_reg + 1'b1;
                    end
                end

                // First pass: sum of the lane's samples.
                ST_SUM: begin
                    if (scan_busy) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (rd_pend_reg) begin
                        sum_reg <= sum_reg + bast_pkg::SUM_W'(signed'(mem_q));
                    end
                    if (!scan_busy && !rd_pend_reg) begin
                        div_dividend_reg <= bast_pkg::DIV_W'(sum_reg[bast_pkg::SUM_W-1]
                                                             ? -sum_reg : sum_reg);
                        div_divisor_reg  <= n_reg;
                        state_reg        <= ST_DIVM;
                    end
                end

                ST_DIVM: begin
                    if (div_done) begin
                        mean_reg     <= mean_new;
                        pos_reg      <= bast_pkg::sat32({mean_new[31], mean_new}
                                                        - {tare_reg[lane_reg][31],
                                                           tare_reg[lane_reg]});
                        cnt_reg      <= '0;
                        acc_reg      <= '0;
                        absd_vld_reg <= 1'b0;
                        sq_vld_reg   <= 1'b0;
                        state_reg    <= ST_SQ;
                    end
                end

                // Second pass: sum of squared deviations, registered after
                // the subtract and after the multiply.
                ST_SQ: begin
                    if (scan_busy) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    absd_vld_reg <= rd_pend_reg;
                    absd_reg     <= diff[bast_pkg::SMP_W] ? 33'(-diff) : 33'(diff);
                    sq_vld_reg   <= absd_vld_reg;
                    sq_reg       <= bast_pkg::SQ_W'(absd_reg * absd_reg);
                    if (sq_vld_reg) begin
                        acc_reg <= acc_reg + bast_pkg::ACC_W'(sq_reg);
                    end
                    if (!scan_busy && !rd_pend_reg && !absd_vld_reg && !sq_vld_reg) begin
                        div_dividend_reg <= acc_reg;
                        div_divisor_reg  <= n_reg - 1'b1;
                        state_reg        <= ST_DIVV;
                    end
                end

                ST_DIVV: begin
                    if (div_done) begin
                        rad_reg   <= var_sat ? '1 : div_q[bast_pkg::RAD_W-1:0];
                        state_reg <= ST_SQRT;
                    end
                end

                ST_SQRT: begin
                    if (sqrt_done) begin
                        dev_reg   <= sqrt_root;
                        state_reg <= ST_RES;
                    end
                end

                // Report the lane, or take its mean as the new tare offset.
                ST_RES: begin
                    if (zeroing_reg || out_free) begin
                        if (zeroing_reg) begin
                            tare_reg[lane_reg] <= pos_reg;
                        end
                        if (lane_reg == bast_pkg::LANE_W'(bast_pkg::CHANNELS - 1)) begin
                            zeroing_reg      <= 1'b0;
                            sample_index_reg <= '0;
                            state_reg        <= ST_IDLE;
                        end else begin
                            lane_reg  <= lane_reg + 1'b1;
                            state_reg <= ST_LANE;
                        end
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    // The block index never runs past the memory depth.
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_index_reg <= bast_pkg::CNT_W'(bast_pkg::AVG_MAX))
        else $error("sample index beyond memory depth");

    // The divider is never restarted while it is still working.
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> !div_busy)
        else $error("divider restarted while busy");

    // A result word is loaded only into a free output register.
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid || m_tready))
        else $error("result overwrote a waiting word");

    // No input word is taken while the memory scan is running.
    a_no_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |-> !s_tready)
        else $error("input accepted during memory scan");
`endif

endmodule

FILE: hdl/bast_divider.sv
// Restoring divider, one quotient bit per cycle, for the block mean and variance.
// Depends on bast_pkg for its widths.
module bast_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [bast_pkg::DIV_W-1:0]   dividend,
    input  logic [bast_pkg::CNT_W-1:0]   divisor,
    output logic                         done,
    output logic                         busy,
    output logic [bast_pkg::DIV_W-1:0]   quotient
);

    logic [bast_pkg::CNT_W-1:0]     rem_reg;
    logic [bast_pkg::CNT_W-1:0]     dsr_reg;
    logic [bast_pkg::DIV_W-1:0]     quo_reg;
    logic [bast_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [bast_pkg::CNT_W:0]       trial;
    logic                           fits;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign trial = {rem_reg, quo_reg[bast_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                quo_reg  <= dividend;
            end else if (busy_reg) begin
                rem_reg <= fits ? bast_pkg::CNT_W'(trial - {1'b0, dsr_reg})
                                : trial[bast_pkg::CNT_W-1:0];
                quo_reg <= {quo_reg[bast_pkg::DIV_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bast_pkg::DIV_CNT_W'(bast_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/bast_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on bast_pkg for its widths.
module bast_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bast_pkg::RAD_W-1:0]    radicand,
    output logic                          done,
    output logic [bast_pkg::ROOT_W-1:0]   root
);

    localparam int REM_W = bast_pkg::ROOT_W + 3;

    logic [bast_pkg::RAD_W-1:0]          rad_reg;
    logic [REM_W-1:0]                    rem_reg;
    logic [bast_pkg::ROOT_W-1:0]         root_reg;
    logic [$clog2(bast_pkg::ROOT_W)-1:0] cnt_reg;
    logic                                busy_reg;
    logic                                done_reg;
    logic [REM_W-1:0]                    rem_sh;
    logic [REM_W-1:0]                    trial;
    logic                                fits;

    // Bring down two radicand bits and test the next root bit.
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[bast_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[bast_pkg::RAD_W-3:0], 2'b00};
                rem_reg  <= fits ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[bast_pkg::ROOT_W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == $clog2(bast_pkg::ROOT_W)'(bast_pkg::ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: tb/tb_checker.sv
`timescale 1ns / 1ps
// Checker for the block average / deviation core: watches the s_, m_ and cfg_
// channels, predicts each result word and compares it. Depends on bast_pkg.
module tb_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [127:0] s_tdata,
    input  logic         s_tuser,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_addr,
    input  logic [10:0]  cfg_data,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic [1:0]  channel;
        logic [31:0] position;
        logic [31:0] deviation;
        logic        averaged;
        logic        last;
    } lane_result_t;

    lane_result_t    expected_q[$];
    logic [3:0]      lane_mask;
    logic [10:0]     block_len;
    logic [31:0]     lane_samples [bast_pkg::CHANNELS][bast_pkg::AVG_MAX];
    logic signed [31:0] tare [bast_pkg::CHANNELS];
    int unsigned     fill_idx;
    bit              taring;

    assign pending = expected_q.size();

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] root_floor(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] b;
        r = '0;
        b = 128'd1 << 126;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return (r > 128'hffff_ffff) ? 32'hffff_ffff : r[31:0];
    endfunction

    // Work out the results of one accepted word and update the lane state.
    task automatic predict_word(input logic [127:0] data, input logic zreq);
        int unsigned n;
        int          first_new;
        longint      total;
        longint      mean;
        longint      d;
        logic [127:0] sq_acc;
        logic [127:0] var_q;
        logic signed [31:0] pos;
        lane_result_t r;
        n = (block_len > bast_pkg::AVG_MAX) ? bast_pkg::AVG_MAX : block_len;
        first_new = expected_q.size();
        if (zreq) begin
            for (int i = 0; i < bast_pkg::CHANNELS; i++) tare[i] = '0;
            if (n <= 1) return;
            fill_idx = 0;
            taring = 1;
        end
        if (n <= 1) begin
            for (int i = 0; i < bast_pkg::CHANNELS; i++) begin
                if (!lane_mask[i]) continue;
                r.channel = 2'(i);
                r.position = clamp32(longint'($signed(data[32*i +: 32])) - tare[i]);
                r.deviation = '0;
                r.averaged = 1'b0;
                r.last = 1'b0;
                expected_q.push_back(r);
            end
        end else begin
            if (fill_idx >= n) fill_idx = 0;
            for (int i = 0; i < bast_pkg::CHANNELS; i++)
                if (lane_mask[i]) lane_samples[i][fill_idx] = data[32*i +: 32];
            fill_idx++;
            if (fill_idx != n) return;
            for (int i = 0; i < bast_pkg::CHANNELS; i++) begin
                if (!lane_mask[i]) continue;
                total = 0;
                for (int j = 0; j < n; j++) total += longint'($signed(lane_samples[i][j]));
                mean = total / longint'(n);
                sq_acc = '0;
                for (int j = 0; j < n; j++) begin
                    d = longint'($signed(lane_samples[i][j])) - mean;
                    if (d < 0) d = -d;
                    sq_acc += 128'(d) * 128'(d);
                end
                var_q = sq_acc / 128'(n - 1);
                if (var_q > 128'hffff_ffff_ffff_ffff) var_q = 128'hffff_ffff_ffff_ffff;
                pos = clamp32(mean - tare[i]);
                if (taring) begin
                    tare[i] = pos;
                end else begin
                    r.channel = 2'(i);
                    r.position = pos;
                    r.deviation = root_floor(var_q);
                    r.averaged = 1'b1;
                    r.last = 1'b0;
                    expected_q.push_back(r);
                end
            end
            taring = 0;
            fill_idx = 0;
        end
        if (expected_q.size() > first_new) expected_q[$].last = 1'b1;
    endtask

    // Observe all three channels at each rising edge.
    always @(posedge aclk) begin
        lane_result_t want;
        if (!aresetn) begin
            lane_mask <= bast_pkg::ALL_LANES;
            block_len <= 11'd10;
            for (int i = 0; i < bast_pkg::CHANNELS; i++) tare[i] = '0;
            fill_idx = 0;
            taring = 0;
            fail_count = 0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_addr == bast_pkg::REG_CHANNEL_ENABLE) lane_mask <= cfg_data[3:0];
                else block_len <= cfg_data;
            end
            if (s_tvalid && s_tready) predict_word(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result word: %h %h", m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser[1:0] !== want.channel) begin
                        $error("channel: expected %0d, got %0d", want.channel, m_tuser[1:0]);
                        fail_count++;
                    end
                    if (m_tdata[31:0] !== want.position) begin
                        $error("position: expected %0d, got %0d",
                               $signed(want.position), $signed(m_tdata[31:0]));
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== want.deviation) begin
                        $error("deviation: expected %0d, got %0d",
                               want.deviation, m_tdata[63:32]);
                        fail_count++;
                    end
                    if (m_tuser[2] !== want.averaged) begin
                        $error("averaged: expected %0d, got %0d", want.averaged, m_tuser[2]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for block_average_stddev_with_tare_core: drives words and
// register writes, stalls the receiver, and gives the verdict. Uses tb_checker.
module tb_top;

    localparam int WATCHDOG_CYCLES = 400000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic [127:0] s_tdata = 0;
    logic         s_tuser = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic         cfg_addr = 0;
    logic [10:0]  cfg_data = 0;
    int           fail_count;
    int           pending;
    bit           calm = 0;
    bit           hold_off = 0;
    int           quiet_cycles = 0;

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    block_average_stddev_with_tare_core u_top (.*);

    tb_checker u_checker (.*);

    // Receiver: random stall bursts, a long hold-off on request, none when calm.
    initial begin
        int gap;
        @(negedge aclk);
        forever begin
            if (hold_off) begin
                m_tready <= 0;
                repeat (3000) @(negedge aclk);
                hold_off = 0;
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 4);
                m_tready <= 0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1;
            @(negedge aclk);
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("[block_average_stddev_with_tare_core] ERROR");
            $finish;
        end
    end

    // Offer one word; valid drops again at the falling edge after acceptance.
    task automatic send_word(input logic [127:0] data, input logic zreq);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tdata  = data;
        s_tuser  = zreq;
        s_tvalid = 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge aclk);
        repeat (12000) @(negedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic [10:0] value);
        cfg_addr  = addr;
        cfg_data  = value;
        cfg_valid = 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    function automatic logic [31:0] rand_sample(input int spread);
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return $urandom_range(0, spread) - spread / 2;
        endcase
    endfunction

    function automatic logic [127:0] rand_word();
        return {rand_sample(2000), rand_sample(2000), rand_sample(2000), rand_sample(2000)};
    endfunction

    initial begin
        int n;
        repeat (11) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: pass-through extremes, tare clear, no lanes enabled.
        write_reg(bast_pkg::REG_AVERAGE_COUNT, 11'd1);
        send_word({32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0}, 1'b0);
        send_word({4{32'h5555_aaaa}}, 1'b1);
        send_word({32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_fffe}, 1'b0);
        wait_idle();
        write_reg(bast_pkg::REG_AVERAGE_COUNT, 11'd0);
        send_word({4{32'haaaa_5555}}, 1'b0);
        wait_idle();
        write_reg(bast_pkg::REG_CHANNEL_ENABLE, 11'h0);
        send_word(rand_word(), 1'b0);
        wait_idle();

        // Tare from a two-sample block of extremes, then saturating results.
        write_reg(bast_pkg::REG_CHANNEL_ENABLE, 11'hf);
        write_reg(bast_pkg::REG_AVERAGE_COUNT, 11'd2);
        send_word({32'h8000_0000, 32'h7fff_ffff, 32'h0000_0064, 32'h8000_0000}, 1'b1);
        send_word({32'h8000_0000, 32'h7fff_ffff, 32'h0000_0064, 32'h7fff_ffff}, 1'b0);
        send_word({32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000}, 1'b0);
        send_word({32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff}, 1'b0);
        // Tared pass-through, then a partial block cut short by a lower count.
        wait_idle();
        write_reg(bast_pkg::REG_AVERAGE_COUNT, 11'd1);
        send_word({32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1}, 1'b0);
        wait_idle();
        write_reg(bast_pkg::REG_AVERAGE_COUNT, 11'd5);
        repeat (3) send_word(rand_word(), 1'b0);
        wait_idle();
        write_reg(bast_pkg::REG_AVERAGE_COUNT, 11'd3);
        repeat (3) send_word(rand_word(), 1'b0);
        wait_idle();
        // Count above the store depth saturates; the partial block is cut short later.
        write_reg(bast_pkg::REG_AVERAGE_COUNT, 11'd2047);
        repeat (16) send_word(rand_word(), 1'b0);
        wait_idle();

        // Long receiver hold-off while words keep coming in pass-through.
        write_reg(bast_pkg::REG_AVERAGE_COUNT, 11'd0);
        hold_off = 1;
        repeat (12) send_word(rand_word(), 1'b0);
        wait_idle();

        // Random phases: new mask and count each, whole blocks plus noise.
        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 7) calm = 1;
            write_reg(bast_pkg::REG_CHANNEL_ENABLE, 11'($urandom_range(1, 15)));
            n = (phase % 4 == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
            write_reg(bast_pkg::REG_AVERAGE_COUNT, 11'(n));
            repeat ((n <= 1) ? 8 : 2 * n)
                send_word(rand_word(), $urandom_range(0, 11) == 0);
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("[block_average_stddev_with_tare_core] OK");
        end else begin
            $display("[block_average_stddev_with_tare_core] ERROR");
        end
        $finish;
    end

endmodule
